// File: sv/c3s_pkg.sv
// c3s_pkg: shared types and widths for the 3x3 cramer solver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package c3s_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;              // field width
    localparam int PW        = 2 * W;           // 32x32 product
    localparam int MW        = PW + 1;          // 2x2 minor
    localparam int DW        = 98;              // signed 3x3 determinant
    localparam int MAGW      = DW - 1;          // determinant magnitude
    localparam int QW        = 32;              // quotient bits
    localparam int RW        = MAGW + QW + 1;   // divider remainder width
    localparam int NLANE     = 3;

    localparam logic [QW-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic signed [W-1:0] col_a_x;
        logic signed [W-1:0] col_a_y;
        logic signed [W-1:0] col_a_z;
        logic signed [W-1:0] col_b_x;
        logic signed [W-1:0] col_b_y;
        logic signed [W-1:0] col_b_z;
        logic signed [W-1:0] col_c_x;
        logic signed [W-1:0] col_c_y;
        logic signed [W-1:0] col_c_z;
        logic signed [W-1:0] rhs_x;
        logic signed [W-1:0] rhs_y;
        logic signed [W-1:0] rhs_z;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] sol_x;
        logic signed [W-1:0] sol_y;
        logic signed [W-1:0] sol_z;
        logic                singular;
        logic                overflow;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic                        singular;
        logic [NLANE-1:0]            neg;
        logic [MAGW-1:0]             den;
        logic [NLANE-1:0][MAGW-1:0]  num;
    } t_cls_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: sv/c3s_front.sv
// c3s_front: accepts items and forms the four determinants, then classifies them
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_front import c3s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    input  logic      i_q_full,
    output logic      o_busy,
    output logic      o_push,
    output t_cls_item o_cls
);

    // vector sets for the cross products: (b,c), (r,c), (b,r)
    localparam int SU [3] = '{1, 3, 1};
    localparam int SV [3] = '{2, 2, 3};

    logic signed [W-1:0]  w_vec [4][3];
    logic                 w_adv;
    logic [3:0]           r_v;

    logic signed [PW-1:0] r_pr  [3][3][2];
    logic signed [W-1:0]  r_a1  [3];
    logic signed [W-1:0]  r_r1  [3];
    logic signed [MW-1:0] r_cr  [3][3];
    logic signed [W-1:0]  r_a2  [3];
    logic signed [W-1:0]  r_r2  [3];
    logic signed [MW:0]   r_plo [4][3];
    logic signed [MW:0]   r_phi [4][3];
    logic signed [DW-1:0] r_det [4];
    logic signed [DW-1:0] n_det [4];

    function automatic logic [MAGW-1:0] f_mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] t;
        t = v[DW-1] ? (~v + 1'b1) : v;
        return t[MAGW-1:0];
    endfunction

    assign w_vec[0][0] = i_item.col_a_x;
    assign w_vec[0][1] = i_item.col_a_y;
    assign w_vec[0][2] = i_item.col_a_z;
    assign w_vec[1][0] = i_item.col_b_x;
    assign w_vec[1][1] = i_item.col_b_y;
    assign w_vec[1][2] = i_item.col_b_z;
    assign w_vec[2][0] = i_item.col_c_x;
    assign w_vec[2][1] = i_item.col_c_y;
    assign w_vec[2][2] = i_item.col_c_z;
    assign w_vec[3][0] = i_item.rhs_x;
    assign w_vec[3][1] = i_item.rhs_y;
    assign w_vec[3][2] = i_item.rhs_z;

    // the whole front holds while the queue cannot take its last stage
    assign w_adv  = !(i_q_full && r_v[3]);
    assign o_busy = !w_adv;
    assign o_push = r_v[3] && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < 3; s++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pr[s][k][0] <= w_vec[SU[s]][(k + 1) % 3] * w_vec[SV[s]][(k + 2) % 3];
                    r_pr[s][k][1] <= w_vec[SU[s]][(k + 2) % 3] * w_vec[SV[s]][(k + 1) % 3];
                    r_cr[s][k]    <= {r_pr[s][k][0][PW-1], r_pr[s][k][0]}
                                   - {r_pr[s][k][1][PW-1], r_pr[s][k][1]};
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= w_vec[0][k];
                r_r1[k] <= w_vec[3][k];
                r_a2[k] <= r_a1[k];
                r_r2[k] <= r_r1[k];
            end
            // dot products as two partial products per term: D, D1, D2, D3
            for (int k = 0; k < 3; k++) begin
                r_plo[0][k] <= r_a2[k] * $signed({1'b0, r_cr[0][k][W-1:0]});
                r_phi[0][k] <= r_a2[k] * $signed(r_cr[0][k][MW-1:W]);
                r_plo[1][k] <= r_r2[k] * $signed({1'b0, r_cr[0][k][W-1:0]});
                r_phi[1][k] <= r_r2[k] * $signed(r_cr[0][k][MW-1:W]);
                r_plo[2][k] <= r_a2[k] * $signed({1'b0, r_cr[1][k][W-1:0]});
                r_phi[2][k] <= r_a2[k] * $signed(r_cr[1][k][MW-1:W]);
                r_plo[3][k] <= r_a2[k] * $signed({1'b0, r_cr[2][k][W-1:0]});
                r_phi[3][k] <= r_a2[k] * $signed(r_cr[2][k][MW-1:W]);
            end
            r_det <= n_det;
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_det[j] = '0;
            for (int k = 0; k < 3; k++) begin
                n_det[j] = n_det[j] + (DW'(r_phi[j][k]) <<< W) + DW'(r_plo[j][k]);
            end
        end
    end

    always_comb begin
        o_cls.singular = (r_det[0] == '0);
        o_cls.den      = f_mag(r_det[0]);
        for (int l = 0; l < NLANE; l++) begin
            o_cls.neg[l] = r_det[0][DW-1] ^ r_det[l+1][DW-1];
            o_cls.num[l] = f_mag(r_det[l+1]);
        end
    end

endmodule

// File: sv/c3s_queue.sv
// c3s_queue: two-entry queue of classified items between front and back
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_queue import c3s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_data,
    input  logic      i_pop,
    output t_q_stat   o_stat,
    output t_cls_item o_data
);

    t_cls_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: sv/c3s_back.sv
// c3s_back: pipelined restoring divider, three lanes, then saturation and sign
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_back import c3s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_item i_cls,
    output logic      o_done,
    output t_out_item o_result
);

    logic [QW:0]      r_v;
    logic [MAGW-1:0]  r_den  [QW];
    logic [RW-1:0]    r_rem  [QW+1][NLANE];
    logic [QW-1:0]    r_q    [QW+1][NLANE];
    logic [NLANE-1:0] r_ovf  [QW+1];
    logic [NLANE-1:0] r_neg  [QW+1];
    logic             r_sing [QW+1];

    logic             r_done;
    t_out_item        r_res;
    t_out_item        n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[QW-1:0], i_valid};
            r_done <= r_v[QW];
        end
    end

    // entry: scale numerators; a quotient of 2^32 or more is flagged here
    always_ff @(posedge i_clk) begin
        r_den[0]  <= i_cls.den;
        r_neg[0]  <= i_cls.neg;
        r_sing[0] <= i_cls.singular;
        for (int l = 0; l < NLANE; l++) begin
            r_rem[0][l] <= RW'(i_cls.num[l]) << FRAC_BITS;
            r_q[0][l]   <= '0;
            r_ovf[0][l] <= (RW'(i_cls.num[l]) << FRAC_BITS) >= (RW'(i_cls.den) << QW);
        end
    end

    for (genvar t = 1; t <= QW; t++) begin : g_step
        localparam int SH = QW - t;
        logic [RW-1:0]    w_sh;
        logic [NLANE-1:0] w_ge;

        assign w_sh = RW'(r_den[t-1]) << SH;
        for (genvar l = 0; l < NLANE; l++) begin : g_lane
            assign w_ge[l] = (r_rem[t-1][l] >= w_sh);
        end

        // the last stage has no later user of the divisor
        if (t < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                r_den[t] <= r_den[t-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[t]  <= r_neg[t-1];
            r_sing[t] <= r_sing[t-1];
            r_ovf[t]  <= r_ovf[t-1];
            for (int l = 0; l < NLANE; l++) begin
                r_rem[t][l] <= w_ge[l] ? (r_rem[t-1][l] - w_sh) : r_rem[t-1][l];
                r_q[t][l]   <= {r_q[t-1][l][QW-2:0], w_ge[l]};
            end
        end
    end

    always_comb begin
        logic [QW-1:0]    lim [NLANE];
        logic [QW-1:0]    qm  [NLANE];
        logic [QW-1:0]    val [NLANE];
        logic [NLANE-1:0] sat;
        for (int l = 0; l < NLANE; l++) begin
            lim[l] = r_neg[QW][l] ? NEG_LIMIT : POS_LIMIT;
            sat[l] = r_ovf[QW][l] || (r_q[QW][l] > lim[l]);
            qm[l]  = sat[l] ? lim[l] : r_q[QW][l];
            val[l] = r_neg[QW][l] ? (~qm[l] + 1'b1) : qm[l];
        end
        if (r_sing[QW]) begin
            n_res.sol_x    = '0;
            n_res.sol_y    = '0;
            n_res.sol_z    = '0;
            n_res.singular = 1'b1;
            n_res.overflow = 1'b0;
        end else begin
            n_res.sol_x    = $signed(val[0]);
            n_res.sol_y    = $signed(val[1]);
            n_res.sol_z    = $signed(val[2]);
            n_res.singular = 1'b0;
            n_res.overflow = |sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// File: sv/cramer_3x3_solver.sv
// cramer_3x3_solver: top level, front, queue and divider back end
// depends on c3s_pkg, c3s_front, c3s_queue, c3s_back
//
// Usage:
//   Input channel: drive i_item and raise i_start; the transaction is taken at
//   a rising edge with i_start high and o_busy low. A new system may be
//   offered every cycle.
//   Output channel: o_done is high for one cycle with o_result valid; the
//   result is taken at the edge that ends that cycle and cannot be held off.
//   Results leave in the order the systems were accepted.
// Pipeline and throughput:
//   an accepted system passes through the product, cross-product, partial
//   dot-product and determinant registers, the queue entry, the numerator
//   scaling register, 32 restoring divider stages (one quotient bit each)
//   and the output register, after which o_done rises. Sustained throughput is
//   one system per cycle; o_busy only rises if the queue fills, which the
//   always-draining back end prevents.
// Reset: i_rst_n low synchronously clears all valid state; in-flight systems
//   are dropped and o_done is low on the following cycle.
`timescale 1ns / 1ps

module cramer_3x3_solver import c3s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_done,
    output t_out_item o_result
);

    logic      w_push;
    t_cls_item w_cls;
    t_q_stat   w_stat;
    t_cls_item w_q_data;

    c3s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .i_q_full (w_stat.full),
        .o_busy   (o_busy),
        .o_push   (w_push),
        .o_cls    (w_cls)
    );

    c3s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls),
        .i_pop   (!w_stat.empty),
        .o_stat  (w_stat),
        .o_data  (w_q_data)
    );

    c3s_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_stat.empty),
        .i_cls    (w_q_data),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: sv/c3s_checker.sv
// c3s_checker: port-level assertions for cramer_3x3_solver, bound to the top
// depends on c3s_pkg
`timescale 1ns / 1ps

module c3s_checker import c3s_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_done,
    input t_out_item o_result
);

    // a singular system gives zero solutions and no overflow
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.singular |->
            o_result.sol_x == 0 && o_result.sol_y == 0 && o_result.sol_z == 0
            && !o_result.overflow)
        else $error("singular result not cleared");

    // overflow means at least one lane sits on a saturation limit
    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.overflow |->
            $unsigned(o_result.sol_x) == POS_LIMIT || $unsigned(o_result.sol_x) == NEG_LIMIT
            || $unsigned(o_result.sol_y) == POS_LIMIT || $unsigned(o_result.sol_y) == NEG_LIMIT
            || $unsigned(o_result.sol_z) == POS_LIMIT || $unsigned(o_result.sol_z) == NEG_LIMIT)
        else $error("overflow without saturated lane");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule

bind cramer_3x3_solver c3s_checker u_c3s_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_done   (o_done),
    .o_result (o_result)
);
